### rtl/core/wsd_pkg.sv
// Shared types and constants for the WebSocket frame deframer.
`default_nettype none
package wsd_pkg;

   // Parser phase: head bytes, extended length, mask key, payload
   typedef enum logic [2:0] {
      PH_HEAD0   = 3'd0,
      PH_HEAD1   = 3'd1,
      PH_EXTLEN  = 3'd2,
      PH_MASK    = 3'd3,
      PH_PAYLOAD = 3'd4
   } phase_type;

   typedef enum logic [1:0] {
      KIND_DATA  = 2'd0,
      KIND_END   = 2'd1,
      KIND_PONG  = 2'd2,
      KIND_ERROR = 2'd3
   } kind_type;

   localparam int unsigned CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_MSG_SIZE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CLIENT_MODE  = 2'd1;

   localparam logic [31:0] MAX_MSG_SIZE_RESET = 32'(1024 * 1024 * 32);

   localparam logic [3:0] OPC_CONT  = 4'h0;
   localparam logic [3:0] OPC_LAST_DATA = 4'h2;
   localparam logic [3:0] OPC_CLOSE = 4'h8;
   localparam logic [3:0] OPC_PING  = 4'h9;

   localparam logic [6:0] LEN7_EXT16 = 7'd126;
   localparam logic [6:0] LEN7_EXT64 = 7'd127;
   localparam logic [3:0] EXT16_BYTES = 4'd2;
   localparam logic [3:0] EXT64_BYTES = 4'd8;
   localparam logic [3:0] MASK_BYTES  = 4'd4;

   typedef struct packed {
      logic [31:0] max_msg_size;
      logic        client_mode;
   } csr_type;

   typedef struct packed {
      kind_type    kind;
      logic [7:0]  data;
      logic [3:0]  opcode;
      logic        last;
   } result_type;

endpackage
`default_nettype wire

### rtl/core/wsd_csr.sv
// Configuration registers of the deframer.
`default_nettype none
module wsd_csr
   import wsd_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 csr_valid,
   output logic                      csr_ready,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [31:0]          csr_wdata,
   output csr_type                   csr
);

   csr_type csr_ff;
   csr_type csr_in;

   assign csr_ready = 1'b1;
   assign csr = csr_ff;

   always_comb begin
      csr_in = csr_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_MAX_MSG_SIZE: csr_in.max_msg_size = csr_wdata;
            CSR_CLIENT_MODE:  csr_in.client_mode  = csr_wdata[0];
            default:          csr_in = csr_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff.max_msg_size <= MAX_MSG_SIZE_RESET;
         csr_ff.client_mode  <= 1'b0;
      end else begin
         csr_ff <= csr_in;
      end
   end

endmodule
`default_nettype wire

### rtl/core/wsd_in_reg.sv
// Input register holding one received byte until the parser takes it.
`default_nettype none
module wsd_in_reg
   import wsd_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_tvalid,
   output logic            req_tready,
   input  wire logic [7:0] req_tdata,
   input  wire logic       step,
   output logic            in_valid,
   output logic [7:0]      in_byte
);

   logic       valid_ff;
   logic       valid_in;
   logic [7:0] byte_ff;

   // Take a new byte when empty or when the held one is consumed now
   assign req_tready = !valid_ff || step;
   assign in_valid   = valid_ff;
   assign in_byte    = byte_ff;

   always_comb begin
      if (req_tvalid && req_tready) begin
         valid_in = 1'b1;
      end else if (step) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         byte_ff <= req_tdata;
      end
   end

endmodule
`default_nettype wire

### rtl/core/wsd_parser.sv
// Frame parser: state registers and the per-byte step logic.
`default_nettype none
module wsd_parser
   import wsd_pkg::*;
#(
   parameter int unsigned MSG_LEN_BITS = 32
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       step,
   input  wire logic [7:0] rx_byte,
   input  wire csr_type    csr,
   output logic            res_valid,
   output result_type      res
);

   // Message length never reaches the limit, which fits in 32 bits at most
   localparam int unsigned LW = (MSG_LEN_BITS < 32) ? MSG_LEN_BITS : 32;
   localparam logic [31:0] LenMax = 32'((64'd1 << LW) - 64'd1);

   phase_type   phase_ff, phase_in;
   logic        final_ff, final_in;
   logic [3:0]  opcode_ff, opcode_in;
   logic        masked_ff, masked_in;
   logic [3:0]  left_ff, left_in;
   logic [63:0] remain_ff, remain_in;
   logic [31:0] key_ff, key_in;
   logic [1:0]  pos_ff, pos_in;
   logic [LW-1:0] msg_len_ff, msg_len_in;
   logic [3:0]  msg_kind_ff, msg_kind_in;
   logic        closed_ff, closed_in;

   logic [6:0]    len7;
   logic          is_data;
   logic [63:0]   ext_len;
   logic [63:0]   lk_len;
   logic [63:0]   sp_len;
   logic          lk_masked;
   logic [LW-1:0] limit;
   logic [LW-1:0] room;
   logic          too_big;
   logic [3:0]    kind_upd;
   logic [7:0]    key_byte;
   logic          do_lk;
   logic          do_sp;

   assign len7     = rx_byte[6:0];
   assign is_data  = (opcode_ff <= OPC_LAST_DATA);
   assign ext_len  = {remain_ff[55:0], rx_byte};
   assign lk_len   = (phase_ff == PH_HEAD1) ? 64'(len7) : ext_len;
   assign sp_len   = (phase_ff == PH_MASK) ? remain_ff : lk_len;
   assign lk_masked = (phase_ff == PH_HEAD1) ? rx_byte[7] : masked_ff;
   assign kind_upd = (msg_kind_ff == OPC_CONT && opcode_ff != OPC_CONT) ?
                     opcode_ff : msg_kind_ff;

   always_comb begin
      if (csr.max_msg_size > LenMax) begin
         limit = LenMax[LW-1:0];
      end else begin
         limit = csr.max_msg_size[LW-1:0];
      end
   end

   assign room    = limit - msg_len_ff;
   assign too_big = (msg_len_ff >= limit) || (lk_len >= 64'(room));

   always_comb begin
      unique case (pos_ff)
         2'd0:    key_byte = key_ff[31:24];
         2'd1:    key_byte = key_ff[23:16];
         2'd2:    key_byte = key_ff[15:8];
         default: key_byte = key_ff[7:0];
      endcase
   end

   always_comb begin
      phase_in    = phase_ff;
      final_in    = final_ff;
      opcode_in   = opcode_ff;
      masked_in   = masked_ff;
      left_in     = left_ff;
      remain_in   = remain_ff;
      key_in      = key_ff;
      pos_in      = pos_ff;
      msg_len_in  = msg_len_ff;
      msg_kind_in = msg_kind_ff;
      closed_in   = closed_ff;
      res_valid   = 1'b0;
      res         = '0;
      do_lk       = 1'b0;
      do_sp       = 1'b0;

      if (closed_ff) begin
         res_valid = 1'b1;
         res.kind  = KIND_ERROR;
      end else begin
         unique case (phase_ff)
            PH_HEAD1: begin
               masked_in = rx_byte[7];
               if (is_data && !csr.client_mode && !rx_byte[7]) begin
                  res_valid = 1'b1;
                  res.kind  = KIND_ERROR;
                  closed_in = 1'b1;
               end else if (len7 == LEN7_EXT16 || len7 == LEN7_EXT64) begin
                  left_in   = (len7 == LEN7_EXT16) ? EXT16_BYTES : EXT64_BYTES;
                  remain_in = '0;
                  phase_in  = PH_EXTLEN;
                  if (opcode_ff == OPC_PING) begin
                     res_valid = 1'b1;
                     res.kind  = KIND_PONG;
                  end
               end else if (opcode_ff == OPC_PING) begin
                  // request pong now, skip the payload
                  remain_in = 64'(len7);
                  res_valid = 1'b1;
                  res.kind  = KIND_PONG;
                  if (rx_byte[7]) begin
                     phase_in = PH_MASK;
                     left_in  = MASK_BYTES;
                     key_in   = '0;
                  end else if (len7 == '0) begin
                     phase_in = PH_HEAD0;
                  end else begin
                     phase_in = PH_PAYLOAD;
                     pos_in   = '0;
                  end
               end else begin
                  remain_in = 64'(len7);
                  do_lk     = 1'b1;
               end
            end
            PH_EXTLEN: begin
               remain_in = ext_len;
               left_in   = left_ff - 4'd1;
               if (left_ff == 4'd1) begin
                  do_lk = 1'b1;
               end
            end
            PH_MASK: begin
               key_in  = {key_ff[23:0], rx_byte};
               left_in = left_ff - 4'd1;
               if (left_ff == 4'd1) begin
                  do_sp = 1'b1;
               end
            end
            PH_PAYLOAD: begin
               pos_in    = pos_ff + 2'd1;
               remain_in = remain_ff - 64'd1;
               if (is_data) begin
                  res_valid  = 1'b1;
                  res.kind   = KIND_DATA;
                  res.data   = masked_ff ? (rx_byte ^ key_byte) : rx_byte;
                  res.opcode = msg_kind_ff;
                  res.last   = (remain_ff == 64'd1) && final_ff;
               end
               if (remain_ff == 64'd1) begin
                  phase_in = PH_HEAD0;
                  if (is_data) begin
                     if (final_ff) begin
                        msg_len_in  = '0;
                        msg_kind_in = '0;
                     end
                  end else if (opcode_ff == OPC_CLOSE) begin
                     closed_in = 1'b1;
                  end
               end
            end
            default: begin
               final_in  = rx_byte[7];
               opcode_in = rx_byte[3:0];
               phase_in  = PH_HEAD1;
            end
         endcase

         // Full payload length known: check the message limit, then move on
         if (do_lk) begin
            if (is_data && too_big) begin
               res_valid = 1'b1;
               res.kind  = KIND_ERROR;
               closed_in = 1'b1;
            end else begin
               if (is_data) begin
                  msg_len_in  = msg_len_ff + lk_len[LW-1:0];
                  msg_kind_in = kind_upd;
               end
               if (lk_masked) begin
                  phase_in = PH_MASK;
                  left_in  = MASK_BYTES;
                  key_in   = '0;
               end else begin
                  do_sp = 1'b1;
               end
            end
         end

         if (do_sp) begin
            if (sp_len == 64'd0) begin
               phase_in = PH_HEAD0;
               if (is_data) begin
                  if (final_ff) begin
                     res_valid   = 1'b1;
                     res.kind    = KIND_END;
                     res.opcode  = msg_kind_in;
                     res.last    = 1'b1;
                     msg_len_in  = '0;
                     msg_kind_in = '0;
                  end
               end else if (opcode_ff == OPC_CLOSE) begin
                  closed_in = 1'b1;
               end
            end else begin
               phase_in = PH_PAYLOAD;
               pos_in   = '0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_HEAD0;
         msg_len_ff  <= '0;
         msg_kind_ff <= '0;
         closed_ff   <= 1'b0;
      end else if (step) begin
         phase_ff    <= phase_in;
         msg_len_ff  <= msg_len_in;
         msg_kind_ff <= msg_kind_in;
         closed_ff   <= closed_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         final_ff  <= final_in;
         opcode_ff <= opcode_in;
         masked_ff <= masked_in;
         left_ff   <= left_in;
         remain_ff <= remain_in;
         key_ff    <= key_in;
         pos_ff    <= pos_in;
      end
   end

endmodule
`default_nettype wire

### rtl/core/wsd_out_reg.sv
// Result register driving the response stream.
`default_nettype none
module wsd_out_reg
   import wsd_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        step,
   input  wire logic        res_valid,
   input  wire result_type  res,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [15:0]      rsp_tdata,
   output logic [1:0]       rsp_tuser,
   output logic             rsp_tlast
);

   logic       valid_ff;
   logic       valid_in;
   result_type res_ff;

   always_comb begin
      if (step) begin
         valid_in = res_valid;
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step && res_valid) begin
         res_ff <= res;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = {4'd0, res_ff.opcode, res_ff.data};
   assign rsp_tuser  = res_ff.kind;
   assign rsp_tlast  = res_ff.last;

endmodule
`default_nettype wire

### rtl/core/websocket_frame_deframer.sv
// WebSocket frame deframer: receives one byte per transaction, one result per byte at most.
// Each accepted byte sits in an input register, is parsed by one pass of logic and
// its result, if any, lands in an output register, from which it is presented; one byte
// per clock is taken for as long as the response side keeps up, since a single parser
// step updates all frame state for each byte.
// Results are payload bytes (tuser 0, unmasked, with the message opcode, tlast on the
// last byte of a message), an empty message end (tuser 1), a pong request (tuser 2) on
// the second head byte of a ping, and an error (tuser 3) after which every byte gives
// an error until reset. Payloads of control and unknown frames are skipped.
`default_nettype none
module websocket_frame_deframer
   import wsd_pkg::*;
#(
   parameter int unsigned MSG_LEN_BITS = 32
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_tvalid,
   output logic                      req_tready,
   input  wire logic [7:0]           req_tdata,   // [7:0] rx_byte
   output logic                      rsp_tvalid,
   input  wire logic                 rsp_tready,
   output logic [15:0]               rsp_tdata,   // [7:0] data_byte, [11:8] message_opcode
   output logic [1:0]                rsp_tuser,   // [1:0] result_kind
   output logic                      rsp_tlast,
   input  wire logic                 csr_valid,
   output logic                      csr_ready,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [31:0]          csr_wdata
);

   csr_type    csr;
   logic       in_valid;
   logic [7:0] in_byte;
   logic       out_free;
   logic       step;
   logic       res_valid;
   result_type res;

   // Parse the held byte whenever the result register can take its result
   assign out_free = !rsp_tvalid || rsp_tready;
   assign step     = in_valid && out_free;

   wsd_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .csr       (csr)
   );

   wsd_in_reg u_in_reg (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .step       (step),
      .in_valid   (in_valid),
      .in_byte    (in_byte)
   );

   wsd_parser #(
      .MSG_LEN_BITS (MSG_LEN_BITS)
   ) u_parser (
      .clock     (clock),
      .reset     (reset),
      .step      (step),
      .rx_byte   (in_byte),
      .csr       (csr),
      .res_valid (res_valid),
      .res       (res)
   );

   wsd_out_reg u_out_reg (
      .clock      (clock),
      .reset      (reset),
      .step       (step),
      .res_valid  (res_valid),
      .res        (res),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

`ifndef SYNTH
   a_err_pong_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == KIND_ERROR || rsp_tuser == KIND_PONG)
      |-> !rsp_tlast && rsp_tdata == 16'd0)
      else $error("error or pong result carries payload fields");

   a_end_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == KIND_END |-> rsp_tlast && rsp_tdata[7:0] == 8'd0)
      else $error("empty message end without last marker");

   a_hold_input: assert property (@(posedge clock) disable iff (reset)
      in_valid && !out_free |=> in_valid && $stable(in_byte))
      else $error("held input byte lost while result side stalled");
`endif

endmodule
`default_nettype wire

### tb/sv/websocket_frame_deframer_checker.sv
// Watches the deframer channels, predicts every result and compares it with the block's output.
module websocket_frame_deframer_checker
   import wsd_pkg::*;
#(
   parameter int unsigned MSG_LEN_BITS = 32
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   input  logic                 req_tready,
   input  logic [7:0]           req_tdata,   // [7:0] rx_byte
   input  logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   input  logic [15:0]          rsp_tdata,   // [7:0] data_byte, [11:8] message_opcode
   input  logic [1:0]           rsp_tuser,   // [1:0] result_kind
   input  logic                 rsp_tlast,
   input  logic                 csr_valid,
   input  logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [31:0]          csr_wdata,
   output int                   fail_count,
   output int                   outstanding
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [63:0] LEN_MASK =
      (MSG_LEN_BITS >= 64) ? '1 : ((64'd1 << MSG_LEN_BITS) - 64'd1);

   // configuration copy
   logic [31:0] size_limit;
   logic        client;

   // parser state copy
   phase_type   ph;
   logic        fin;
   logic [3:0]  fop;
   logic        fmask;
   logic [3:0]  field_left;
   logic [63:0] remaining;
   logic [31:0] key;
   logic [1:0]  kpos;
   logic [63:0] msg_len;
   logic [3:0]  msg_op;
   logic        shut;

   result_type  pending_results[$];
   int          mismatches = 0;

   initial begin
      fail_count = 0;
      outstanding = 0;
   end

   task automatic expect_result(input kind_type k, input logic [7:0] d, input logic [3:0] op,
                                input logic last);
      result_type r;
      r.kind = k;
      r.data = d;
      r.opcode = op;
      r.last = last;
      pending_results.push_back(r);
   endtask

   task automatic raise_error;
      shut = 1'b1;
      expect_result(KIND_ERROR, 8'h00, 4'h0, 1'b0);
   endtask

   task automatic end_frame(input bit empty);
      ph = PH_HEAD0;
      if (fop <= OPC_LAST_DATA) begin
         if (fin) begin
            if (empty) expect_result(KIND_END, 8'h00, msg_op, 1'b1);
            msg_len = 64'd0;
            msg_op = OPC_CONT;
         end
      end else if (fop == OPC_CLOSE) begin
         shut = 1'b1;
      end
   endtask

   task automatic enter_mask;
      ph = PH_MASK;
      field_left = MASK_BYTES;
      key = 32'd0;
   endtask

   task automatic open_payload;
      if (remaining == 64'd0) begin
         end_frame(1'b1);
      end else begin
         ph = PH_PAYLOAD;
         kpos = 2'd0;
      end
   endtask

   // Apply the message size limit once a data frame's length is complete.
   task automatic length_ready;
      logic [63:0] lim;
      if (fop <= OPC_LAST_DATA) begin
         lim = {32'd0, size_limit};
         if (lim > LEN_MASK) lim = LEN_MASK;
         if (msg_len >= lim || remaining >= lim - msg_len) begin
            raise_error();
            return;
         end
         msg_len = (msg_len + remaining) & LEN_MASK;
         if (msg_op == OPC_CONT && fop != OPC_CONT) msg_op = fop;
      end
      if (fmask) enter_mask();
      else open_payload();
   endtask

   task automatic parse_byte(input logic [7:0] b);
      logic [7:0] d;
      if (shut) begin
         expect_result(KIND_ERROR, 8'h00, 4'h0, 1'b0);
         return;
      end
      case (ph)
         PH_HEAD1: begin
            fmask = b[7];
            if (fop <= OPC_LAST_DATA && !client && !fmask) begin
               raise_error();
            end else if (b[6:0] == LEN7_EXT16 || b[6:0] == LEN7_EXT64) begin
               field_left = (b[6:0] == LEN7_EXT16) ? EXT16_BYTES : EXT64_BYTES;
               remaining = 64'd0;
               ph = PH_EXTLEN;
               if (fop == OPC_PING) expect_result(KIND_PONG, 8'h00, 4'h0, 1'b0);
            end else begin
               remaining = {57'd0, b[6:0]};
               if (fop == OPC_PING) begin
                  // short ping: ask for the pong now, then skip its payload
                  if (fmask) begin
                     enter_mask();
                  end else if (remaining == 64'd0) begin
                     ph = PH_HEAD0;
                  end else begin
                     ph = PH_PAYLOAD;
                     kpos = 2'd0;
                  end
                  expect_result(KIND_PONG, 8'h00, 4'h0, 1'b0);
               end else begin
                  length_ready();
               end
            end
         end
         PH_EXTLEN: begin
            remaining = {remaining[55:0], b};
            field_left = field_left - 4'd1;
            if (field_left == 4'd0) length_ready();
         end
         PH_MASK: begin
            key = {key[23:0], b};
            field_left = field_left - 4'd1;
            if (field_left == 4'd0) open_payload();
         end
         PH_PAYLOAD: begin
            d = fmask ? (b ^ key[8*(3-kpos) +: 8]) : b;
            kpos = kpos + 2'd1;
            remaining = remaining - 64'd1;
            if (fop <= OPC_LAST_DATA)
               expect_result(KIND_DATA, d, msg_op, (remaining == 64'd0) && fin);
            if (remaining == 64'd0) end_frame(1'b0);
         end
         default: begin
            fin = b[7];
            fop = b[3:0];
            ph = PH_HEAD1;
         end
      endcase
   endtask

   task automatic check_field(input string name, input int unsigned want,
                              input int unsigned got);
      if (want != got) begin
         $error("%s: expected %0d, actual %0d", name, want, got);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin
      result_type e;
      if (reset) begin
         size_limit = MAX_MSG_SIZE_RESET;
         client = 1'b0;
         ph = PH_HEAD0;
         fin = 1'b0;
         fop = OPC_CONT;
         fmask = 1'b0;
         field_left = 4'd0;
         remaining = 64'd0;
         key = 32'd0;
         kpos = 2'd0;
         msg_len = 64'd0;
         msg_op = OPC_CONT;
         shut = 1'b0;
         pending_results.delete();
      end else begin
         // compare first so a stray result cannot match an expectation made at this edge
         if (rsp_tvalid && rsp_tready) begin
            if (pending_results.size() == 0) begin
               $error("unexpected result: result_kind %0d data_byte %0d", rsp_tuser,
                      rsp_tdata[7:0]);
               mismatches++;
            end else begin
               e = pending_results.pop_front();
               check_field("result_kind", e.kind, rsp_tuser);
               check_field("data_byte", e.data, rsp_tdata[7:0]);
               check_field("message_opcode", e.opcode, rsp_tdata[11:8]);
               check_field("last_of_message", e.last, rsp_tlast);
            end
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_MAX_MSG_SIZE: size_limit = csr_wdata;
               CSR_CLIENT_MODE:  client = csr_wdata[0];
               default: ;
            endcase
         end
         if (req_tvalid && req_tready) parse_byte(req_tdata);
      end
      fail_count <= mismatches;
      outstanding <= pending_results.size();
   end

endmodule

### tb/sv/websocket_frame_deframer_test.sv
// Stimulus and verdict for the WebSocket frame deframer: frame streams under several settings.
module websocket_frame_deframer_test;
   import wsd_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned MSG_LEN_BITS = 32;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int SETTLE_CYCLES = 8;

   localparam logic [CSR_IDX_W-1:0] CSR_IDX_SPARE = 2'd2;

   localparam logic [3:0] OPC_TEXT           = 4'h1;
   localparam logic [3:0] OPC_BINARY         = OPC_LAST_DATA;
   localparam logic [3:0] OPC_PONG           = 4'hA;
   localparam logic [3:0] OPC_DATA_RSV_FIRST = 4'h3;
   localparam logic [3:0] OPC_DATA_RSV_LAST  = 4'h7;
   localparam logic [3:0] OPC_CTRL_RSV_FIRST = 4'hB;
   localparam logic [3:0] OPC_CTRL_RSV_LAST  = 4'hF;

   localparam int FORM_ANY   = -1;
   localparam int FORM_SHORT = 0;
   localparam int FORM_EXT16 = 1;
   localparam int FORM_EXT64 = 2;

   typedef enum int {END_BY_CLOSE, END_BY_UNMASKED, END_BY_OVERSIZE} closing_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_tvalid = 1'b0;
   logic                 req_tready;
   logic [7:0]           req_tdata = 8'h00;   // [7:0] rx_byte
   logic                 rsp_tvalid;
   logic                 rsp_tready = 1'b0;
   logic [15:0]          rsp_tdata;           // [7:0] data_byte, [11:8] message_opcode
   logic [1:0]           rsp_tuser;           // [1:0] result_kind
   logic                 rsp_tlast;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [31:0]          csr_wdata = 32'd0;

   int fail_count;
   int outstanding;
   int quiet_cycles = 0;
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int sent_bytes = 0;

   // generator's view of the current message and settings
   logic [31:0] cur_limit = MAX_MSG_SIZE_RESET;
   logic        cur_client = 1'b0;
   logic        open_message = 1'b0;
   logic [63:0] message_bytes = 64'd0;

   websocket_frame_deframer #(.MSG_LEN_BITS(MSG_LEN_BITS)) dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser), .rsp_tlast(rsp_tlast),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   websocket_frame_deframer_checker #(.MSG_LEN_BITS(MSG_LEN_BITS)) result_watch (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser), .rsp_tlast(rsp_tlast),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_index(csr_index),
      .csr_wdata(csr_wdata),
      .fail_count(fail_count), .outstanding(outstanding)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) rsp_tready <= ($urandom_range(0, 99) >= recv_idle_pct);

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("websocket_frame_deframer_test: errors");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Hold the byte until its transaction completes; valid stays high for a follow-on byte.
   task automatic push_byte(input logic [7:0] b);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= b;
      do @(posedge clock); while (!req_tready);
      sent_bytes++;
   endtask

   task automatic send_frame(input logic fin, input logic [3:0] op, input logic masked,
                             input int unsigned len, input int form);
      int f;
      int unsigned r;
      logic [63:0] len64;
      logic [2:0] rsv;
      f = form;
      if (f == FORM_ANY) begin
         r = $urandom_range(0, 9);
         f = (r < 7) ? FORM_SHORT : (r < 9) ? FORM_EXT16 : FORM_EXT64;
      end
      if (f == FORM_SHORT && len >= LEN7_EXT16) f = FORM_EXT16;
      rsv = ($urandom_range(0, 3) == 0) ? 3'($urandom) : 3'd0;
      len64 = 64'(len);
      push_byte({fin, rsv, op});
      case (f)
         FORM_SHORT: push_byte({masked, len64[6:0]});
         FORM_EXT16: begin
            push_byte({masked, LEN7_EXT16});
            push_byte(len64[15:8]);
            push_byte(len64[7:0]);
         end
         default: begin
            push_byte({masked, LEN7_EXT64});
            for (int i = 7; i >= 0; i--) push_byte(len64[8*i +: 8]);
         end
      endcase
      if (masked) repeat (4) push_byte(8'($urandom));
      repeat (len)
         push_byte(($urandom_range(0, 9) == 0) ? 8'h00 :
                   ($urandom_range(0, 8) == 0) ? 8'hFF : 8'($urandom));
   endtask

   // Mostly well-formed data messages; broken fragment order and skipped frames mixed in.
   task automatic random_frame;
      int unsigned r;
      int unsigned len;
      logic [63:0] room;
      logic fin;
      logic masked;
      logic [3:0] op;
      r = $urandom_range(0, 99);
      fin = 1'($urandom_range(0, 1));
      masked = cur_client ? 1'($urandom_range(0, 1)) : 1'b1;
      if (r < 65) begin
         if (!open_message)
            op = ($urandom_range(0, 9) == 0) ? OPC_CONT :
                 ($urandom_range(0, 1) ? OPC_TEXT : OPC_BINARY);
         else
            op = ($urandom_range(0, 9) == 0) ? OPC_TEXT : OPC_CONT;
         r = $urandom_range(0, 99);
         len = (r < 70) ? $urandom_range(0, 12) :
               (r < 95) ? $urandom_range(13, 60) : $urandom_range(126, 300);
         // stay below the message size limit
         room = {32'd0, cur_limit} - message_bytes - 64'd1;
         if (64'(len) > room) len = 32'(room);
         send_frame(fin, op, masked, len, FORM_ANY);
         if (fin) begin
            open_message = 1'b0;
            message_bytes = 64'd0;
         end else begin
            open_message = 1'b1;
            message_bytes = message_bytes + 64'(len);
         end
      end else if (r < 80) begin
         send_frame(fin, OPC_PING, masked, $urandom_range(0, 8), FORM_ANY);
      end else begin
         r = $urandom_range(0, 2);
         op = (r == 0) ? OPC_PONG :
              (r == 1) ? 4'($urandom_range(OPC_DATA_RSV_FIRST, OPC_DATA_RSV_LAST)) :
                         4'($urandom_range(OPC_CTRL_RSV_FIRST, OPC_CTRL_RSV_LAST));
         send_frame(fin, op, masked, $urandom_range(0, 10), FORM_ANY);
      end
   endtask

   // Drop valid, wait for every expected result, then let the pipeline drain.
   task automatic settle;
      req_tvalid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(input logic [CSR_IDX_W-1:0] idx, input logic [31:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      do @(posedge clock); while (!csr_ready);
   endtask

   task automatic configure(input logic [31:0] limit, input logic client);
      csr_write(CSR_MAX_MSG_SIZE, limit);
      csr_write(CSR_CLIENT_MODE, {31'($urandom), client});
      csr_write(CSR_IDX_W'(CSR_IDX_SPARE + $urandom_range(0, 1)), $urandom);
      csr_valid <= 1'b0;
      cur_limit = limit;
      cur_client = client;
   endtask

   task automatic run_phase(input int nbytes);
      int target;
      target = sent_bytes + nbytes;
      while (sent_bytes < target) random_frame();
      if (open_message) begin
         send_frame(1'b1, OPC_CONT, 1'b1, 0, FORM_ANY);
         open_message = 1'b0;
         message_bytes = 64'd0;
      end
      settle();
   endtask

   initial begin
      closing_type how;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      send_idle_pct = 38;
      recv_idle_pct = 53;
      configure(32'hFFFF_FFFF, 1'b0);

      // text, fragmented binary with a ping between fragments, empty final continuation
      send_frame(1'b1, OPC_TEXT, 1'b1, 2, FORM_SHORT);
      send_frame(1'b0, OPC_BINARY, 1'b1, 1, FORM_EXT16);
      send_frame(1'b1, OPC_PING, 1'b1, 0, FORM_SHORT);
      send_frame(1'b1, OPC_CONT, 1'b1, 0, FORM_SHORT);
      settle();

      run_phase(350);
      configure(32'd1, 1'b1);
      run_phase(150);

      send_idle_pct = 53;
      recv_idle_pct = 38;
      configure(32'd40, 1'b1);
      run_phase(400);

      send_idle_pct = 0;
      recv_idle_pct = 0;
      configure(MAX_MSG_SIZE_RESET, 1'b0);
      run_phase(450);

      // close the block one way, then confirm every later byte gives an error result
      how = closing_type'($urandom_range(0, 2));
      case (how)
         END_BY_CLOSE:
            send_frame(1'b1, OPC_CLOSE, 1'($urandom_range(0, 1)), $urandom_range(0, 4),
                       FORM_ANY);
         END_BY_UNMASKED:
            send_frame(1'b1, OPC_TEXT, 1'b0, $urandom_range(1, 5), FORM_SHORT);
         default: begin
            push_byte({1'b1, 3'b000, OPC_BINARY});
            push_byte({1'b1, LEN7_EXT64});
            push_byte(8'h80 | 8'($urandom));
            repeat (7) push_byte(8'($urandom));
         end
      endcase
      repeat (12) push_byte(8'($urandom));
      settle();

      if (fail_count == 0 && outstanding == 0)
         $display("websocket_frame_deframer_test: clean");
      else
         $display("websocket_frame_deframer_test: errors");
      $finish;
   end

endmodule
